### hw/rtl/compass_heading_from_magnetometer_unit_macros.svh
// assertion macros for the compass heading unit
`ifndef COMPASS_HEADING_FROM_MAGNETOMETER_UNIT_MACROS_SVH
`define COMPASS_HEADING_FROM_MAGNETOMETER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define CHC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chc assertion failed");
`define CHC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chc assertion failed");
`else
`define CHC_ASSERT_IMPL(lbl, ante, cons)
`define CHC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/chc_pkg.sv
// shared constants, types and angle table for the compass heading unit
package chc_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int GUARD_BITS   = 8;
    localparam int TABLE_LEN    = 24;
    localparam int NUM_STEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int STEP_W       = $clog2(TABLE_LEN);

    // sample plus guard bits, one bit for the negation and two for cordic growth
    localparam int CW           = SAMPLE_WIDTH + GUARD_BITS + 3;
    localparam int ANGLE_W      = 32;
    localparam int HEADING_W    = 13;
    localparam int DECL_W       = 13;
    localparam int PROD_W       = ANGLE_W + HEADING_W;
    localparam int SUM_W        = HEADING_W + 2;
    localparam int FULL_CIRCLE  = 5760;

    localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int REG_IDX_W    = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_DECLINATION = 1'b0;

    typedef struct packed {
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        logic [ANGLE_W-1:0]    z;
        logic                  zero;
    } cordic_vec_t;

    // atan(2^-i) as a binary fraction of a full turn
    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic [ANGLE_W-1:0] v;
        unique case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/compass_heading_from_magnetometer_unit.sv
// Compass heading unit: takes one signed X/Y magnetometer pair per transfer and returns
// the heading atan2(y, x) plus the programmed declination, wrapped into 0..5759 sixteenths
// of a degree. A new pair is taken every cycle while in_stall is low. Between input and
// result lie one entry register for the half-plane fold, one register per cordic
// micro-rotation cell, one register after the 32x13 scaling multiply and the output
// register after the declination add. Every stage has its own valid bit, so a stalled
// result only holds back the stages behind it once the bubbles ahead of them are filled.
// The declination register sits at APB address 0.
module compass_heading_from_magnetometer_unit
    import chc_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] x_value,
    input  logic signed [SAMPLE_WIDTH-1:0] y_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [HEADING_W-1:0]           heading,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [APB_ADDR_W-1:0]          paddr,
    input  logic [APB_DATA_W-1:0]          pwdata,
    output logic [APB_DATA_W-1:0]          prdata,
    output logic                           pready
);

`include "compass_heading_from_magnetometer_unit_macros.svh"

    logic [DECL_W-1:0]    decl_reg;
    logic [DECL_W-1:0]    decl_next;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    logic                 entry_valid_reg;
    logic                 entry_valid_next;
    cordic_vec_t          entry_reg;
    cordic_vec_t          entry_next;
    logic                 entry_load;
    logic signed [CW-1:0] x_scaled;
    logic signed [CW-1:0] y_scaled;

    logic                 chain_valid [NUM_STEPS+1];
    cordic_vec_t          chain_data  [NUM_STEPS+1];
    logic                 chain_ready [NUM_STEPS+1];

    // configuration port
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign decl_next = (cfg_write && (reg_idx == REG_DECLINATION))
                       ? pwdata[DECL_W-1:0] : decl_reg;

    always_comb
    begin
        if (reg_idx == REG_DECLINATION)
        begin
            prdata = {{(APB_DATA_W-DECL_W){decl_reg[DECL_W-1]}}, decl_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= '0;
        end
        else
        begin
            decl_reg <= decl_next;
        end
    end

    // entry stage: guard bits, then fold the left half-plane by 180 degrees
    always_comb
    begin
        x_scaled = {{(CW-SAMPLE_WIDTH-GUARD_BITS){x_value[SAMPLE_WIDTH-1]}},
                    x_value, {GUARD_BITS{1'b0}}};
        y_scaled = {{(CW-SAMPLE_WIDTH-GUARD_BITS){y_value[SAMPLE_WIDTH-1]}},
                    y_value, {GUARD_BITS{1'b0}}};
        entry_next.zero = (x_value == '0) && (y_value == '0);
        if (x_value[SAMPLE_WIDTH-1])
        begin
            entry_next.x = -x_scaled;
            entry_next.y = -y_scaled;
            entry_next.z = HALF_TURN;
        end
        else
        begin
            entry_next.x = x_scaled;
            entry_next.y = y_scaled;
            entry_next.z = '0;
        end
    end

    assign entry_load       = !entry_valid_reg || chain_ready[0];
    assign in_stall         = !entry_load;
    assign entry_valid_next = entry_load ? in_valid : entry_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_load && in_valid)
        begin
            entry_reg <= entry_next;
        end
    end

    assign chain_valid[0] = entry_valid_reg;
    assign chain_data[0]  = entry_reg;

    // row of micro-rotation cells
    for (genvar k = 0; k < NUM_STEPS; k++)
    begin : g_cell
        chc_cordic_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .step_idx (STEP_W'(k)),
            .up_valid (chain_valid[k]),
            .up_data  (chain_data[k]),
            .up_ready (chain_ready[k]),
            .dn_valid (chain_valid[k+1]),
            .dn_data  (chain_data[k+1]),
            .dn_ready (chain_ready[k+1])
        );
    end

    chc_heading_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (chain_valid[NUM_STEPS]),
        .up_data     (chain_data[NUM_STEPS]),
        .up_ready    (chain_ready[NUM_STEPS]),
        .declination (decl_reg),
        .dn_valid    (out_valid),
        .dn_heading  (heading),
        .dn_stall    (out_stall)
    );

    `CHC_ASSERT_IMPL(a_heading_range, out_valid, heading < HEADING_W'(FULL_CIRCLE))
    `CHC_ASSERT_IMPL(a_stall_needs_item, in_stall, entry_valid_reg)
    `CHC_ASSERT_NEXT(a_decl_only_on_write, !cfg_write, $stable(decl_reg))

endmodule

### hw/rtl/chc_cordic_cell.sv
// one vectoring cordic micro-rotation with its own pipeline register
module chc_cordic_cell
    import chc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [STEP_W-1:0]  step_idx,
    input  logic               up_valid,
    input  cordic_vec_t        up_data,
    output logic               up_ready,
    output logic               dn_valid,
    output cordic_vec_t        dn_data,
    input  logic               dn_ready
);

    logic                 valid_reg;
    logic                 valid_next;
    cordic_vec_t          data_reg;
    cordic_vec_t          data_next;
    logic                 load;
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] x_sh;
    logic signed [CW-1:0] y_sh;
    logic [ANGLE_W-1:0]   rot;

    assign load     = !valid_reg || dn_ready;
    assign up_ready = load;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        x_in = up_data.x;
        y_in = up_data.y;
        x_sh = x_in >>> step_idx;
        y_sh = y_in >>> step_idx;
        rot  = atan_turn(step_idx);
        data_next      = data_reg;
        data_next.zero = up_data.zero;
        // y of zero counts as non-negative
        if (!y_in[CW-1])
        begin
            data_next.x = x_in + y_sh;
            data_next.y = y_in - x_sh;
            data_next.z = up_data.z + rot;
        end
        else
        begin
            data_next.x = x_in - y_sh;
            data_next.y = y_in + x_sh;
            data_next.z = up_data.z - rot;
        end
    end

    assign valid_next = load ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### hw/rtl/chc_heading_scale.sv
// turn fraction to sixteenths of a degree, then declination add and wrap
module chc_heading_scale
    import chc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    input  cordic_vec_t          up_data,
    output logic                 up_ready,
    input  logic [DECL_W-1:0]    declination,
    output logic                 dn_valid,
    output logic [HEADING_W-1:0] dn_heading,
    input  logic                 dn_stall
);

    logic                  a_valid_reg;
    logic                  a_valid_next;
    logic [HEADING_W-1:0]  h0_reg;
    logic [HEADING_W-1:0]  h0_next;
    logic                  b_valid_reg;
    logic                  b_valid_next;
    logic [HEADING_W-1:0]  heading_reg;
    logic [HEADING_W-1:0]  heading_next;
    logic                  a_load;
    logic                  b_load;
    logic [ANGLE_W-1:0]    angle;
    logic [PROD_W-1:0]     prod;
    logic [PROD_W-1:0]     rounded;
    logic [HEADING_W-1:0]  h0_raw;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] wrapped;

    assign b_load   = !b_valid_reg || !dn_stall;
    assign a_load   = !a_valid_reg || b_load;
    assign up_ready = a_load;

    // stage a: round half up to sixteenths, a full circle folds to zero
    always_comb
    begin
        angle   = up_data.zero ? '0 : up_data.z;
        prod    = PROD_W'(angle) * PROD_W'(FULL_CIRCLE);
        rounded = prod + PROD_W'(HALF_TURN);
        h0_raw  = rounded[PROD_W-1:ANGLE_W];
        h0_next = (h0_raw == HEADING_W'(FULL_CIRCLE)) ? '0 : h0_raw;
    end

    // stage b: add declination, single correction either way
    always_comb
    begin
        sum = $signed({{(SUM_W-HEADING_W){1'b0}}, h0_reg})
            + $signed({{(SUM_W-DECL_W){declination[DECL_W-1]}}, declination});
        priority if (sum[SUM_W-1])
        begin
            wrapped = sum + $signed(SUM_W'(FULL_CIRCLE));
        end
        else if (sum >= $signed(SUM_W'(FULL_CIRCLE)))
        begin
            wrapped = sum - $signed(SUM_W'(FULL_CIRCLE));
        end
        else
        begin
            wrapped = sum;
        end
        heading_next = wrapped[HEADING_W-1:0];
    end

    assign a_valid_next = a_load ? up_valid : a_valid_reg;
    assign b_valid_next = b_load ? a_valid_reg : b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load && up_valid)
        begin
            h0_reg <= h0_next;
        end
        if (b_load && a_valid_reg)
        begin
            heading_reg <= heading_next;
        end
    end

    assign dn_valid   = b_valid_reg;
    assign dn_heading = heading_reg;

endmodule
